// ----- rtl/esc_telemetry_pulse_decoder_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the telemetry pulse decoder
// Clocked, reset-qualified wrappers around concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ESC_TELEMETRY_PULSE_DECODER_TOP_ASSERT_SVH
`define ESC_TELEMETRY_PULSE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication
`define ESC_TPD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ESC_TPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/esc_tpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Telemetry pulse decoder package
// Transaction types, mode codes and arithmetic constants.
// ----------------------------------------------------------------------------
package esc_tpd_pkg;

  localparam int unsigned FRAME_ITEMS = 11;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned NUM_W       = 26;   // (2^16 - 1) * 1000 fits in 26 bits

  localparam logic [1:0] MODE_LISTEN  = 2'd0;
  localparam logic [1:0] MODE_CAPTURE = 2'd1;
  localparam logic [1:0] MODE_DRIVE   = 2'd2;

  localparam logic [15:0] MIN_DELAY_RESET = 16'd950;
  localparam logic [9:0]  CAL_FULL        = 10'd1000;
  // floor(x / 10) == (x * 0xCCCD) >> 19 for every 16-bit x
  localparam logic [15:0] DIV10_RECIP     = 16'hCCCD;
  localparam int unsigned DIV10_SHIFT     = 19;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] timestamp;
    logic [15:0] drive_length;
  } in_item_t;

  typedef struct packed {
    logic [12:0] voltage;
    logic [13:0] current;
    logic        span_error;
  } out_item_t;

  // Frame items needed to compute one result
  typedef struct packed {
    logic [15:0] d0;
    logic [15:0] d1;
    logic [15:0] d3;
    logic [15:0] d9;
    logic [15:0] d10;
  } job_t;

endpackage

// ----- rtl/esc_telemetry_pulse_decoder_top.sv -----
// Throughput: one input transaction per cycle while the job queue has room; the frame
//   result rate is set by the shared restoring divider (26 steps per quotient,
//   two quotients per frame).
// Reset: asynchronous, clears control state and loads min_delay with 950; no clearing pass.
// ----------------------------------------------------------------------------
// ESC telemetry pulse decoder
// Front end decodes listen, capture and drive events and gathers an eleven-item
// frame; a queue hands full frames to the back end, which calibrates them.
// ----------------------------------------------------------------------------
module esc_telemetry_pulse_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  esc_tpd_pkg::in_item_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output esc_tpd_pkg::out_item_t out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [15:0]            cfg_data_i
);
  import esc_tpd_pkg::*;

  // Job handoff between the two halves
  logic job_push, job_full, job_pop, job_empty;
  job_t job_in, job_out;

  // Front end: accepts every transaction unless the queue is full, so
  // listen and drive events keep flowing while a frame is being calibrated
  esc_tpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cfg_ready_o(cfg_ready_o),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full)
  );

  // Hold completed frames until the back end is free
  esc_tpd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (job_push),
    .push_data_i(job_in),
    .full_o     (job_full),
    .pop_i      (job_pop),
    .pop_data_o (job_out),
    .empty_o    (job_empty)
  );

  // Back end: span, numerators, two divisions and the final scaling (both skipped on a zero span); the
  // result register lets the next frame start while a result waits
  esc_tpd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (job_empty),
    .job_i      (job_out),
    .pop_o      (job_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// ----- rtl/esc_tpd_front.sv -----
// ----------------------------------------------------------------------------
// Telemetry pulse decoder front end
// Classifies events, tracks arming and frame index, collects pulse delays.
// ----------------------------------------------------------------------------
module esc_tpd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  esc_tpd_pkg::in_item_t in_data_i,
  output logic                  in_ready_o,
  input  logic                  cfg_valid_i,
  input  logic [15:0]           cfg_data_i,
  output logic                  cfg_ready_o,
  output logic                  job_push_o,
  output esc_tpd_pkg::job_t     job_o,
  input  logic                  job_full_i
);
  import esc_tpd_pkg::*;

  logic [15:0]      min_delay_q;
  logic [15:0]      start_time_q, start_time_d;
  logic [IDX_W-1:0] item_index_q, item_index_d;
  logic [IDX_W-1:0] prior_index_q, prior_index_d;
  logic             armed_q, armed_d;
  logic [15:0]      delay_q [FRAME_ITEMS];

  logic             accept;
  logic [15:0]      delay;
  logic [IDX_W-1:0] listen_index;
  logic             store;

  assign in_ready_o  = !job_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign delay       = in_data_i.timestamp - start_time_q;
  assign listen_index = (prior_index_q == item_index_q) ? '0 : item_index_q;

  always_comb begin
    start_time_d  = start_time_q;
    item_index_d  = item_index_q;
    prior_index_d = prior_index_q;
    armed_d       = armed_q;
    store         = 1'b0;
    unique case (in_data_i.mode)
      MODE_LISTEN: begin
        start_time_d  = in_data_i.timestamp;
        item_index_d  = listen_index;
        prior_index_d = listen_index;
        armed_d       = 1'b1;
      end
      MODE_CAPTURE: begin
        if (armed_q && (delay > min_delay_q)) begin
          armed_d = 1'b0;
          if (item_index_q < IDX_W'(FRAME_ITEMS)) begin
            store        = 1'b1;
            item_index_d = item_index_q + 1'b1;
          end
        end
      end
      MODE_DRIVE: begin
        if (in_data_i.drive_length != '0) begin
          armed_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Last item of the frame goes straight into the job with the stored ones
  assign job_push_o = accept && store && (item_index_q == IDX_W'(FRAME_ITEMS - 1));
  assign job_o.d0   = delay_q[0];
  assign job_o.d1   = delay_q[1];
  assign job_o.d3   = delay_q[3];
  assign job_o.d9   = delay_q[FRAME_ITEMS-2];
  assign job_o.d10  = delay;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_delay_q   <= MIN_DELAY_RESET;
      start_time_q  <= '0;
      item_index_q  <= '0;
      prior_index_q <= '0;
      armed_q       <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        min_delay_q <= cfg_data_i;
      end
      if (accept) begin
        start_time_q  <= start_time_d;
        item_index_q  <= item_index_d;
        prior_index_q <= prior_index_d;
        armed_q       <= armed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && store) begin
      delay_q[item_index_q] <= delay;
    end
  end

endmodule

// ----- rtl/esc_tpd_queue.sv -----
// ----------------------------------------------------------------------------
// Telemetry pulse decoder job queue
// Small FIFO decoupling the front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module esc_tpd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  esc_tpd_pkg::job_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output esc_tpd_pkg::job_t pop_data_o,
  output logic              empty_o
);
  import esc_tpd_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  assign full_o     = (count_q == CW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/esc_tpd_div.sv -----
// ----------------------------------------------------------------------------
// Telemetry pulse decoder divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module esc_tpd_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [esc_tpd_pkg::NUM_W-1:0] num_i,
  input  logic [15:0]                   den_i,
  output logic                          done_o,
  output logic [15:0]                   quot_o
);
  import esc_tpd_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [15:0]      rem_q;
  logic [15:0]      den_q;
  logic [16:0]      trial;
  logic             fits;

  assign trial  = {rem_q, num_q[NUM_W-1]};
  assign fits   = (trial >= {1'b0, den_q});
  assign done_o = done_q;
  assign quot_o = num_q[15:0];   // keep the low 16 quotient bits

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? 16'(trial - {1'b0, den_q}) : trial[15:0];
      num_q <= {num_q[NUM_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/esc_tpd_back.sv -----
// ----------------------------------------------------------------------------
// Telemetry pulse decoder back end
// Calibrates voltage and current of one frame and holds the result.
// ----------------------------------------------------------------------------
module esc_tpd_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  input  esc_tpd_pkg::job_t      job_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output esc_tpd_pkg::out_item_t out_data_o
);
  import esc_tpd_pkg::*;

`include "esc_telemetry_pulse_decoder_top_assert.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LO    = 3'd1;
  localparam logic [2:0] S_DIFF  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIV_V = 3'd4;
  localparam logic [2:0] S_DIV_A = 3'd5;
  localparam logic [2:0] S_SCALE = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]       state_q, state_d;
  job_t             job_q;
  logic [15:0]      lo_q, span_q, diff_v_q, diff_a_q, sv_q, sa_q;
  logic [12:0]      volt_q;
  logic [13:0]      curr_q;
  logic             err_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic             div_start, div_done;
  logic [15:0]      div_quot;
  logic [15:0]      mul_in;
  logic [NUM_W-1:0] mul_out;
  logic [31:0]      volt_prod;
  logic             out_free;

  assign pop_o       = (state_q == S_IDLE) && !empty_i;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // One multiplier shared by both numerators
  assign mul_in    = (state_q == S_MUL) ? diff_v_q : diff_a_q;
  assign mul_out   = NUM_W'(mul_in) * NUM_W'(CAL_FULL);
  assign div_start = ((state_q == S_MUL) && (span_q != '0))
                  || ((state_q == S_DIV_V) && div_done);
  assign volt_prod = {16'b0, sv_q} * {16'b0, DIV10_RECIP};

  esc_tpd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (mul_out),
    .den_i  (span_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (!empty_i) state_d = S_LO;
      S_LO:    state_d = S_DIFF;
      S_DIFF:  state_d = S_MUL;
      S_MUL:   state_d = (span_q == '0) ? S_DONE : S_DIV_V;
      S_DIV_V: if (div_done) state_d = S_DIV_A;
      S_DIV_A: if (div_done) state_d = S_SCALE;
      S_SCALE: state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (state_q == S_LO) begin
      lo_q <= (job_q.d9 < job_q.d10) ? job_q.d9 : job_q.d10;
    end
    if (state_q == S_DIFF) begin
      span_q   <= job_q.d0 - lo_q;
      diff_v_q <= (job_q.d1 < lo_q) ? '0 : job_q.d1 - lo_q;
      diff_a_q <= (job_q.d3 < lo_q) ? '0 : job_q.d3 - lo_q;
    end
    if (state_q == S_MUL) begin
      err_q  <= (span_q == '0);
      volt_q <= '0;
      curr_q <= '0;
    end
    if ((state_q == S_DIV_V) && div_done) begin
      sv_q <= div_quot;
    end
    if ((state_q == S_DIV_A) && div_done) begin
      sa_q <= div_quot;
    end
    if (state_q == S_SCALE) begin
      volt_q <= volt_prod[31:DIV10_SHIFT];
      curr_q <= sa_q[15:2];
    end
    if ((state_q == S_DONE) && out_free) begin
      out_q.voltage    <= volt_q;
      out_q.current    <= curr_q;
      out_q.span_error <= err_q;
    end
  end

  `ESC_TPD_ASSERT_IMPL(a_div_done_in_div, clk_i, rst_ni, div_done,
    (state_q == S_DIV_V) || (state_q == S_DIV_A), "divider finished outside a divide state")
  `ESC_TPD_ASSERT_IMPL(a_pop_in_idle, clk_i, rst_ni, pop_o,
    (state_q == S_IDLE) && !empty_i, "job popped while back end busy or queue empty")
  `ESC_TPD_ASSERT_NEXT(a_err_zero, clk_i, rst_ni, (state_q == S_DONE) && out_free && err_q,
    out_valid_q && (out_q.voltage == '0) && (out_q.current == '0), "span error with values")

endmodule
